[hdl/gbdf_pkg.sv]
package gbdf_pkg;

    // Field widths
    localparam int OP_W     = 3;
    localparam int COORD_W  = 6;
    localparam int STATUS_W = 3;
    localparam int DIST_W   = 13;
    localparam int DIM_W    = 7;
    localparam int CFG_IDX_W = 1;

    // Default grid limits
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam logic [DIM_W-1:0] GRID_DIM_RESET = 7'd64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SET_BLOCKED = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_SOURCE  = 3'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE     = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_DIST   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_SRC   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SOURCES  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OFF_GRID    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SRC_BLOCKED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE       = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Distance values
    localparam logic signed [DIST_W-1:0] DIST_ZERO    = 13'sd0;
    localparam logic signed [DIST_W-1:0] DIST_ONE     = 13'sd1;
    localparam logic signed [DIST_W-1:0] DIST_MAX     = 13'sd4095;
    localparam logic signed [DIST_W-1:0] DIST_UNREACH = -13'sd1;

    // One result word
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DIST_W-1:0] distance;
    } result_t;

endpackage

[hdl/grid_bfs_distance_field_unit.sv]
// Channel   | Signals                                   | Direction
// ----------+-------------------------------------------+----------
// config    | cfg_we, cfg_index, cfg_data               | in
// command   | in_valid/in_ready, operation, cell_x,     | in
//           | cell_y, blocked                           |
// result    | out_valid/out_ready, status, distance     | out
//
// Set blocked, add source and unused codes push their result when taken; a
// read passes S_READ for the registered distance memory read. Clear sources
// sweeps the source memory, one cell a cycle. Compute: a check sweep and a
// fill sweep, then the wavefront: each dequeued cell passes S_Q_RD, S_Q_WAIT
// and S_CUR_WAIT, then S_NB_ISSUE for each of the four directions and
// S_NB_CHECK for each in-grid neighbor. After reset a clearing pass over the
// reachable area holds in_ready low.
// A two-word result queue lets a new command in while a result waits.
module grid_bfs_distance_field_unit #(
    parameter int MAX_WIDTH  = gbdf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gbdf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gbdf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gbdf_pkg::DIM_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [gbdf_pkg::OP_W-1:0]             operation,
    input  logic [gbdf_pkg::COORD_W-1:0]          cell_x,
    input  logic [gbdf_pkg::COORD_W-1:0]          cell_y,
    input  logic                                  blocked,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [gbdf_pkg::STATUS_W-1:0]         status,
    output logic signed [gbdf_pkg::DIST_W-1:0]    distance
);
    import gbdf_pkg::*;

    // Reachable coordinate limits (registers are 7 bits wide)
    localparam int X_LIM = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
    localparam int Y_LIM = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
    localparam int XW    = (X_LIM > 1) ? $clog2(X_LIM) : 1;
    localparam int YW    = (Y_LIM > 1) ? $clog2(Y_LIM) : 1;
    localparam int QW    = XW + YW;
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    // Neighbor order
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_CHECK,
        S_FILL,
        S_Q_RD,
        S_Q_WAIT,
        S_CUR_WAIT,
        S_NB_ISSUE,
        S_NB_CHECK
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
        return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    // Configuration registers
    logic [DIM_W-1:0] grid_w_reg;
    logic [DIM_W-1:0] grid_h_reg;
    logic [DIM_W-1:0] grid_w;
    logic [DIM_W-1:0] grid_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg <= GRID_DIM_RESET;
            grid_h_reg <= GRID_DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_w_reg <= cfg_data;
                REG_GRID_HEIGHT: grid_h_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Effective grid size: zero reads as one, clamp to the maximum
    always_comb
    begin
        if (grid_w_reg == '0)
        begin
            grid_w = DIM_W'(1);
        end
        else if (int'(grid_w_reg) > MAX_WIDTH)
        begin
            grid_w = DIM_W'(X_LIM);
        end
        else
        begin
            grid_w = grid_w_reg;
        end
        if (grid_h_reg == '0)
        begin
            grid_h = DIM_W'(1);
        end
        else if (int'(grid_h_reg) > MAX_HEIGHT)
        begin
            grid_h = DIM_W'(Y_LIM);
        end
        else
        begin
            grid_h = grid_h_reg;
        end
    end

    // Memory ports
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic                     blk_we;
    logic                     blk_wd;
    logic                     src_we;
    logic                     src_wd;
    logic                     dist_we;
    logic signed [DIST_W-1:0] dist_wd;
    logic                     q_we;
    logic [QW-1:0]            q_wd;
    logic [AW-1:0]            q_raddr;

    logic                     blk_mem  [CELLS];
    logic                     src_mem  [CELLS];
    logic signed [DIST_W-1:0] dist_mem [CELLS];
    logic [QW-1:0]            q_mem    [CELLS];

    logic                     blk_rd_reg;
    logic                     src_rd_reg;
    logic signed [DIST_W-1:0] dist_rd_reg;
    logic [QW-1:0]            q_rd_reg;

    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[wr_addr] <= blk_wd;
        end
        blk_rd_reg <= blk_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[wr_addr] <= src_wd;
        end
        src_rd_reg <= src_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[wr_addr] <= dist_wd;
        end
        dist_rd_reg <= dist_mem[rd_addr];
    end

    // Control registers
    state_t                   state_reg, state_next;
    logic [XW-1:0]            sx_reg, sx_next;
    logic [YW-1:0]            sy_reg, sy_next;
    logic                     sweep_end_reg, sweep_end_next;
    logic                     p_vld_reg, p_vld_next;
    logic [XW-1:0]            p_x_reg, p_x_next;
    logic [YW-1:0]            p_y_reg, p_y_next;
    logic                     any_reg, any_next;
    logic                     off_reg, off_next;
    logic                     blkf_reg, blkf_next;
    logic [AW:0]              head_reg, head_next;
    logic [AW:0]              tail_reg, tail_next;
    logic [XW-1:0]            cur_x_reg, cur_x_next;
    logic [YW-1:0]            cur_y_reg, cur_y_next;
    logic [XW-1:0]            nx_reg, nx_next;
    logic [YW-1:0]            ny_reg, ny_next;
    logic [1:0]               k_reg, k_next;
    logic signed [DIST_W-1:0] nd_reg, nd_next;

    // Wavefront queue, written at the tail
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[tail_reg[AW-1:0]] <= q_wd;
        end
        q_rd_reg <= q_mem[q_raddr];
    end

    // Result queue
    logic    push_en;
    result_t push_word;
    result_t out_word;
    logic    space;

    gbdf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_en),
        .push_word (push_word),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    assign status   = out_word.status;
    assign distance = out_word.distance;
    assign in_ready = (state_reg == S_IDLE) && space;

    // Sweep counters over the reachable area, row by row
    logic          sx_last;
    logic          sweep_last;
    logic [XW-1:0] sx_adv;
    logic [YW-1:0] sy_adv;

    assign sx_last    = (sx_reg == XW'(X_LIM - 1));
    assign sweep_last = sx_last && (sy_reg == YW'(Y_LIM - 1));
    assign sx_adv     = sx_last ? '0 : sx_reg + 1'b1;
    assign sy_adv     = sx_last ? sy_reg + 1'b1 : sy_reg;

    // Command decode
    logic [DIM_W-1:0] x_in;
    logic [DIM_W-1:0] y_in;
    logic             in_grid;
    logic [AW-1:0]    in_addr;
    logic             p_in_grid;
    logic             tail_ok;

    assign x_in      = DIM_W'(cell_x);
    assign y_in      = DIM_W'(cell_y);
    assign in_grid   = (x_in < grid_w) && (y_in < grid_h);
    assign in_addr   = cell_addr(x_in[XW-1:0], y_in[YW-1:0]);
    assign p_in_grid = (DIM_W'(p_x_reg) < grid_w) && (DIM_W'(p_y_reg) < grid_h);
    assign tail_ok   = (tail_reg < (AW+1)'(CELLS));

    // Neighbor of the current cell
    logic          nb_ok;
    logic [XW-1:0] nb_x;
    logic [YW-1:0] nb_y;

    always_comb
    begin
        nb_ok = 1'b0;
        nb_x  = cur_x_reg;
        nb_y  = cur_y_reg;
        case (k_reg)
            DIR_LEFT:
            begin
                nb_ok = (cur_x_reg != '0);
                nb_x  = cur_x_reg - 1'b1;
            end
            DIR_UP:
            begin
                nb_ok = (cur_y_reg != '0);
                nb_y  = cur_y_reg - 1'b1;
            end
            DIR_DOWN:
            begin
                nb_ok = ({1'b0, DIM_W'(cur_y_reg)} + (DIM_W+1)'(1)) < {1'b0, grid_h};
                nb_y  = cur_y_reg + 1'b1;
            end
            DIR_RIGHT:
            begin
                nb_ok = ({1'b0, DIM_W'(cur_x_reg)} + (DIM_W+1)'(1)) < {1'b0, grid_w};
                nb_x  = cur_x_reg + 1'b1;
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        sweep_end_next = sweep_end_reg;
        p_vld_next     = 1'b0;
        p_x_next       = sx_reg;
        p_y_next       = sy_reg;
        any_next       = any_reg;
        off_next       = off_reg;
        blkf_next      = blkf_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        k_next         = k_reg;
        nd_next        = nd_reg;

        rd_addr   = '0;
        wr_addr   = '0;
        blk_we    = 1'b0;
        blk_wd    = 1'b0;
        src_we    = 1'b0;
        src_wd    = 1'b0;
        dist_we   = 1'b0;
        dist_wd   = DIST_UNREACH;
        q_we      = 1'b0;
        q_wd      = {p_y_reg, p_x_reg};
        q_raddr   = head_reg[AW-1:0];
        push_en   = 1'b0;
        push_word = '{status: ST_OK, distance: DIST_ZERO};

        case (state_reg)
            // Clearing pass after reset
            S_INIT:
            begin
                wr_addr = cell_addr(sx_reg, sy_reg);
                blk_we  = 1'b1;
                src_we  = 1'b1;
                dist_we = 1'b1;
                sx_next = sx_adv;
                sy_next = sy_adv;
                if (sweep_last)
                begin
                    sx_next    = '0;
                    sy_next    = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (operation)
                        OP_SET_BLOCKED:
                        begin
                            wr_addr = in_addr;
                            blk_wd  = blocked;
                            blk_we  = in_grid;
                            push_en = 1'b1;
                            push_word.status = in_grid ? ST_OK : ST_RANGE;
                        end
                        OP_ADD_SOURCE:
                        begin
                            wr_addr = in_addr;
                            src_wd  = 1'b1;
                            src_we  = in_grid;
                            push_en = 1'b1;
                            push_word.status = in_grid ? ST_OK : ST_RANGE;
                        end
                        OP_COMPUTE:
                        begin
                            sx_next        = '0;
                            sy_next        = '0;
                            sweep_end_next = 1'b0;
                            any_next       = 1'b0;
                            off_next       = 1'b0;
                            blkf_next      = 1'b0;
                            state_next     = S_CHECK;
                        end
                        OP_READ_DIST:
                        begin
                            rd_addr = in_addr;
                            if (in_grid)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                push_en          = 1'b1;
                                push_word.status = ST_RANGE;
                            end
                        end
                        OP_CLEAR_SRC:
                        begin
                            sx_next    = '0;
                            sy_next    = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            push_en = 1'b1;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                push_en            = 1'b1;
                push_word.distance = dist_rd_reg;
                state_next         = S_IDLE;
            end

            // Wipe all source marks
            S_CLEAR:
            begin
                wr_addr = cell_addr(sx_reg, sy_reg);
                src_we  = 1'b1;
                sx_next = sx_adv;
                sy_next = sy_adv;
                if (sweep_last)
                begin
                    sx_next    = '0;
                    sy_next    = '0;
                    push_en    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // Scan marks for off-grid or blocked sources
            S_CHECK:
            begin
                rd_addr    = cell_addr(sx_reg, sy_reg);
                p_vld_next = !sweep_end_reg;
                if (!sweep_end_reg)
                begin
                    sx_next = sx_adv;
                    sy_next = sy_adv;
                    if (sweep_last)
                    begin
                        sweep_end_next = 1'b1;
                    end
                end
                if (p_vld_reg && src_rd_reg)
                begin
                    any_next = 1'b1;
                    if (!p_in_grid)
                    begin
                        off_next = 1'b1;
                    end
                    else if (blk_rd_reg)
                    begin
                        blkf_next = 1'b1;
                    end
                end
                if (sweep_end_reg && !p_vld_reg)
                begin
                    if (!any_reg)
                    begin
                        push_en          = 1'b1;
                        push_word.status = ST_NO_SOURCES;
                        state_next       = S_IDLE;
                    end
                    else if (off_reg)
                    begin
                        push_en          = 1'b1;
                        push_word.status = ST_OFF_GRID;
                        state_next       = S_IDLE;
                    end
                    else if (blkf_reg)
                    begin
                        push_en          = 1'b1;
                        push_word.status = ST_SRC_BLOCKED;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        sx_next        = '0;
                        sy_next        = '0;
                        sweep_end_next = 1'b0;
                        head_next      = '0;
                        tail_next      = '0;
                        state_next     = S_FILL;
                    end
                end
            end

            // Reset distances and seed the queue with the sources
            S_FILL:
            begin
                rd_addr    = cell_addr(sx_reg, sy_reg);
                p_vld_next = !sweep_end_reg;
                if (!sweep_end_reg)
                begin
                    sx_next = sx_adv;
                    sy_next = sy_adv;
                    if (sweep_last)
                    begin
                        sweep_end_next = 1'b1;
                    end
                end
                if (p_vld_reg)
                begin
                    wr_addr = cell_addr(p_x_reg, p_y_reg);
                    dist_we = 1'b1;
                    if (src_rd_reg && p_in_grid && tail_ok)
                    begin
                        dist_wd   = DIST_ZERO;
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                if (sweep_end_reg && !p_vld_reg)
                begin
                    sx_next    = '0;
                    sy_next    = '0;
                    state_next = S_Q_RD;
                end
            end

            // Pop the next wavefront cell
            S_Q_RD:
            begin
                if (head_reg == tail_reg)
                begin
                    push_en    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_Q_WAIT;
                end
            end

            S_Q_WAIT:
            begin
                cur_x_next = q_rd_reg[XW-1:0];
                cur_y_next = q_rd_reg[QW-1:XW];
                rd_addr    = cell_addr(q_rd_reg[XW-1:0], q_rd_reg[QW-1:XW]);
                state_next = S_CUR_WAIT;
            end

            S_CUR_WAIT:
            begin
                nd_next    = (dist_rd_reg >= DIST_MAX) ? DIST_MAX : dist_rd_reg + DIST_ONE;
                k_next     = DIR_LEFT;
                state_next = S_NB_ISSUE;
            end

            S_NB_ISSUE:
            begin
                rd_addr = cell_addr(nb_x, nb_y);
                nx_next = nb_x;
                ny_next = nb_y;
                if (nb_ok)
                begin
                    state_next = S_NB_CHECK;
                end
                else if (k_reg == DIR_RIGHT)
                begin
                    state_next = S_Q_RD;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end

            // Claim a free, unvisited neighbor
            S_NB_CHECK:
            begin
                wr_addr = cell_addr(nx_reg, ny_reg);
                dist_wd = nd_reg;
                q_wd    = {ny_reg, nx_reg};
                if (!blk_rd_reg && dist_rd_reg[DIST_W-1] && tail_ok)
                begin
                    dist_we   = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                if (k_reg == DIR_RIGHT)
                begin
                    state_next = S_Q_RD;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_NB_ISSUE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sweep_end_reg <= 1'b0;
            p_vld_reg     <= 1'b0;
            p_x_reg       <= '0;
            p_y_reg       <= '0;
            any_reg       <= 1'b0;
            off_reg       <= 1'b0;
            blkf_reg      <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            k_reg         <= DIR_LEFT;
            nd_reg        <= DIST_ZERO;
        end
        else
        begin
            state_reg     <= state_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            sweep_end_reg <= sweep_end_next;
            p_vld_reg     <= p_vld_next;
            p_x_reg       <= p_x_next;
            p_y_reg       <= p_y_next;
            any_reg       <= any_next;
            off_reg       <= off_next;
            blkf_reg      <= blkf_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            nx_reg        <= nx_next;
            ny_reg        <= ny_next;
            k_reg         <= k_next;
            nd_reg        <= nd_next;
        end
    end

endmodule

[hdl/gbdf_out_fifo.sv]
module gbdf_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gbdf_pkg::result_t push_word,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output gbdf_pkg::result_t out_word
);
    import gbdf_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_next;
    logic [1:0] count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign out_word  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule
